FILE: sv/dfe_pkg.sv
// dfe_pkg: shared types, codes and the month-length table for the date editor
// no dependencies; imported by every module of the date field editor
`default_nettype none

package dfe_pkg;

  // field widths fixed by the interface
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CurW   = 2;
  localparam int unsigned OpW    = 3;

  // field limits
  localparam logic [MonthW-1:0] MonthMax = MonthW'(12);
  localparam logic [YearW-1:0]  YearMax  = YearW'(9999);
  localparam logic [DayW-1:0]   DayLong  = DayW'(31);
  localparam logic [DayW-1:0]   DayShort = DayW'(30);
  localparam logic [DayW-1:0]   DayFeb   = DayW'(29);

  // reset date
  localparam logic [DayW-1:0]   DayRst   = DayW'(1);
  localparam logic [MonthW-1:0] MonthRst = MonthW'(1);
  localparam logic [YearW-1:0]  YearRst  = YearW'(2016);

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_NONE   = 3'd0,
    OP_UP     = 3'd1,
    OP_RIGHT  = 3'd2,
    OP_DOWN   = 3'd3,
    OP_LEFT   = 3'd4,
    OP_SELECT = 3'd5,
    OP_LOAD   = 3'd6
  } dfe_op_t;

  // cursor positions
  localparam logic [CurW-1:0] CUR_DAY    = 2'd0;
  localparam logic [CurW-1:0] CUR_MONTH  = 2'd1;
  localparam logic [CurW-1:0] CUR_YEAR   = 2'd2;
  localparam logic [CurW-1:0] CUR_SEARCH = 2'd3;

  // edited date plus cursor
  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic [CurW-1:0]   cursor;
  } dfe_date_t;

  // days in a month, february always 29
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    len = DayLong;
    if (m inside {MonthW'(4), MonthW'(6), MonthW'(9), MonthW'(11)}) begin
      len = DayShort;
    end else if (m == MonthW'(2)) begin
      len = DayFeb;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dfe_step.sv
// dfe_step: next date and cursor for one operation, pure combinational logic
// depends on dfe_pkg for codes, widths and the month-length table
`default_nettype none

module dfe_step (
  input  dfe_pkg::dfe_date_t        cur,
  input  logic [dfe_pkg::OpW-1:0]    op,
  input  logic [dfe_pkg::DayW-1:0]   load_day,
  input  logic [dfe_pkg::MonthW-1:0] load_month,
  input  logic [dfe_pkg::YearW-1:0]  load_year,
  output dfe_pkg::dfe_date_t        nxt
);
  import dfe_pkg::*;

  logic [YearW-1:0]  year_inc;
  logic [YearW-1:0]  year_dec;
  logic [MonthW-1:0] month_inc;
  logic [MonthW-1:0] month_dec;
  logic [YearW-1:0]  year_of_inc;
  logic [YearW-1:0]  year_of_dec;
  logic [DayW-1:0]   len_cur;
  logic [DayW-1:0]   len_inc;
  logic [DayW-1:0]   len_dec;
  logic [DayW-1:0]   day_clamp_inc;
  logic [DayW-1:0]   day_clamp_dec;
  logic [MonthW-1:0] ld_month;
  logic [YearW-1:0]  ld_year;
  logic [DayW-1:0]   ld_len;
  logic [DayW-1:0]   ld_day;

  // saturating year step
  assign year_inc = (cur.year < YearMax) ? cur.year + YearW'(1) : cur.year;
  assign year_dec = (cur.year != '0) ? cur.year - YearW'(1) : cur.year;

  // month step with wrap and year carry
  assign month_inc   = (cur.month >= MonthMax) ? MonthW'(1) : cur.month + MonthW'(1);
  assign year_of_inc = (cur.month >= MonthMax) ? year_inc : cur.year;
  assign month_dec   = (cur.month <= MonthW'(1)) ? MonthMax : cur.month - MonthW'(1);
  assign year_of_dec = (cur.month <= MonthW'(1)) ? year_dec : cur.year;

  // month lengths around the current month
  assign len_cur = month_len(cur.month);
  assign len_inc = month_len(month_inc);
  assign len_dec = month_len(month_dec);

  // day clamped to the new month after a month step
  assign day_clamp_inc = (cur.day > len_inc) ? len_inc : cur.day;
  assign day_clamp_dec = (cur.day > len_dec) ? len_dec : cur.day;

  // load clamping
  always_comb begin
    ld_month = load_month;
    if (ld_month < MonthW'(1)) begin
      ld_month = MonthW'(1);
    end else if (ld_month > MonthMax) begin
      ld_month = MonthMax;
    end
    ld_year = (load_year > YearMax) ? YearMax : load_year;
    ld_len  = month_len(ld_month);
    ld_day  = load_day;
    if (ld_day < DayW'(1)) begin
      ld_day = DayW'(1);
    end else if (ld_day > ld_len) begin
      ld_day = ld_len;
    end
  end

  // operation decode
  always_comb begin
    nxt = cur;
    case (dfe_op_t'(op))
      OP_UP: begin
        case (cur.cursor)
          CUR_DAY: begin
            if (cur.day >= len_cur) begin
              nxt.day   = DayW'(1);
              nxt.month = month_inc;
              nxt.year  = year_of_inc;
            end else begin
              nxt.day = cur.day + DayW'(1);
            end
          end
          CUR_MONTH: begin
            nxt.month = month_inc;
            nxt.year  = year_of_inc;
            nxt.day   = day_clamp_inc;
          end
          CUR_YEAR: begin
            nxt.year = year_inc;
          end
          default: begin
          end
        endcase
      end
      OP_DOWN: begin
        case (cur.cursor)
          CUR_DAY: begin
            if (cur.day <= DayW'(1)) begin
              nxt.month = month_dec;
              nxt.year  = year_of_dec;
              nxt.day   = len_dec;
            end else begin
              nxt.day = cur.day - DayW'(1);
            end
          end
          CUR_MONTH: begin
            nxt.month = month_dec;
            nxt.year  = year_of_dec;
            nxt.day   = day_clamp_dec;
          end
          CUR_YEAR: begin
            nxt.year = year_dec;
          end
          default: begin
          end
        endcase
      end
      OP_RIGHT: begin
        // search position holds
        if (cur.cursor == CUR_YEAR) begin
          nxt.cursor = CUR_DAY;
        end else if (cur.cursor != CUR_SEARCH) begin
          nxt.cursor = cur.cursor + CurW'(1);
        end
      end
      OP_LEFT: begin
        nxt.cursor = (cur.cursor == CUR_DAY) ? CUR_YEAR : cur.cursor - CurW'(1);
      end
      OP_SELECT: begin
        nxt.cursor = CUR_SEARCH;
      end
      OP_LOAD: begin
        nxt.day    = ld_day;
        nxt.month  = ld_month;
        nxt.year   = ld_year;
        nxt.cursor = CUR_DAY;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/dfe_state.sv
// dfe_state: date state register that doubles as the result register
// depends on dfe_pkg for the date struct and reset values
`default_nettype none

module dfe_state (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_vld,
  input  dfe_pkg::dfe_date_t nxt,
  input  logic               out_stall,
  output logic               adv,
  output logic               out_vld,
  output dfe_pkg::dfe_date_t cur
);
  import dfe_pkg::*;

  logic      out_vld_r;
  dfe_date_t date_r;

  // result slot frees when empty or taken
  assign adv = !out_vld_r || !out_stall;

  // state and result beat update together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r     <= 1'b0;
      date_r.day    <= DayRst;
      date_r.month  <= MonthRst;
      date_r.year   <= YearRst;
      date_r.cursor <= CUR_DAY;
    end else if (adv) begin
      out_vld_r <= step_vld;
      if (step_vld) begin
        date_r <= nxt;
      end
    end
  end

  assign out_vld = out_vld_r;
  assign cur     = date_r;

endmodule

`default_nettype wire

FILE: sv/date_field_editor.sv
// date_field_editor: top level of the button-driven date editor
// depends on dfe_pkg, dfe_step and dfe_state
//
// Usage: each input beat carries one button operation (none, up, right,
// down, left, select, load) plus a date used only by load. Each accepted
// beat yields exactly one result beat: day, month, year and cursor as they
// stand after that operation.
// Data path: the input register feeds the step logic, whose result is
// written into the state register that drives out_*; one beat per cycle
// while out_stall does not hold the result register.
// The state update depends only on the previous state register, so the
// back-to-back path is the increment, compare and clamp logic.
// Reset (rst_n low, synchronous): date becomes 1 January 2016, cursor on
// day, both pipeline slots empty.
// Receiver stall: the result beat holds; an empty input register still takes
// one more beat, then in_stall rises until the result is taken.
`default_nettype none

module date_field_editor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  output logic                       in_stall,
  input  logic [dfe_pkg::OpW-1:0]    in_operation,
  input  logic [dfe_pkg::DayW-1:0]   in_load_day,
  input  logic [dfe_pkg::MonthW-1:0] in_load_month,
  input  logic [dfe_pkg::YearW-1:0]  in_load_year,
  output logic                       out_vld,
  input  logic                       out_stall,
  output logic [dfe_pkg::DayW-1:0]   out_day_out,
  output logic [dfe_pkg::MonthW-1:0] out_month_out,
  output logic [dfe_pkg::YearW-1:0]  out_year_out,
  output logic [dfe_pkg::CurW-1:0]   out_cursor_out
);
  import dfe_pkg::*;

  logic              s1_vld_r;
  logic [OpW-1:0]    s1_op_r;
  logic [DayW-1:0]   s1_day_r;
  logic [MonthW-1:0] s1_month_r;
  logic [YearW-1:0]  s1_year_r;
  logic              adv;
  dfe_date_t         cur;
  dfe_date_t         nxt;

  // input slot blocks only when full and the result slot is held
  assign in_stall = s1_vld_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_vld) begin
      s1_op_r    <= in_operation;
      s1_day_r   <= in_load_day;
      s1_month_r <= in_load_month;
      s1_year_r  <= in_load_year;
    end
  end

  // next-state logic
  dfe_step u_step (
    .cur        (cur),
    .op         (s1_op_r),
    .load_day   (s1_day_r),
    .load_month (s1_month_r),
    .load_year  (s1_year_r),
    .nxt        (nxt)
  );

  // state and result register
  dfe_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_vld  (s1_vld_r),
    .nxt       (nxt),
    .out_stall (out_stall),
    .adv       (adv),
    .out_vld   (out_vld),
    .cur       (cur)
  );

  assign out_day_out    = cur.day;
  assign out_month_out  = cur.month;
  assign out_year_out   = cur.year;
  assign out_cursor_out = cur.cursor;

  // an empty input slot never pushes back
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> !in_stall)
    else $error("input stalled with empty input slot");

  // state moves only when an operation is retired
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_vld_r && adv) |=> $stable(cur))
    else $error("date state changed without a retired operation");

  // held date is a legal calendar date whenever out_vld is high
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (cur.month >= MonthW'(1) && cur.month <= MonthMax &&
                 cur.day >= DayW'(1) && cur.day <= month_len(cur.month) &&
                 cur.year <= YearMax))
    else $error("illegal date in result register");

endmodule

`default_nettype wire
